// File: rtl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Types, codes and constant tables shared by the text display controller.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int PAL_DEPTH   = 96;
    localparam int PAL_AW      = 7;
    localparam int DIV_W       = 17;
    localparam int DIV_CNT_W   = 5;

    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 1'd1;

    localparam logic [7:0] IO_PAGE     = 8'hd7;
    localparam logic [7:0] CHAR_BLANK  = 8'h20;
    localparam logic [7:0] ATTR_INIT   = 8'h01;
    localparam logic [7:0] PAL_FG_BASE = 8'd16;

    // Register offsets on the I/O page
    localparam logic [7:0] REG_WIN_LEFT   = 8'd0;
    localparam logic [7:0] REG_WIN_TOP    = 8'd1;
    localparam logic [7:0] REG_WIN_COLS   = 8'd2;
    localparam logic [7:0] REG_WIN_ROWS   = 8'd3;
    localparam logic [7:0] REG_SCREEN_W   = 8'd4;
    localparam logic [7:0] REG_SCREEN_H   = 8'd5;
    localparam logic [7:0] REG_CHAR_PAGE  = 8'd6;
    localparam logic [7:0] REG_ATTR_PAGE  = 8'd7;
    localparam logic [7:0] REG_CHARSET    = 8'd8;
    localparam logic [7:0] REG_CONTROL    = 8'd10;
    localparam logic [7:0] REG_IRQ_ENABLE = 8'd14;
    localparam logic [7:0] REG_IRQ_STATUS = 8'd15;

    localparam logic [7:0] BASE_COLORS [48] = '{
        8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h68, 8'h37, 8'h2B, 8'h70, 8'hA4, 8'hB2,
        8'h6F, 8'h3D, 8'h86, 8'h58, 8'h8D, 8'h43, 8'h35, 8'h28, 8'h79, 8'hB8, 8'hC7, 8'h6F,
        8'h6F, 8'h4F, 8'h25, 8'h43, 8'h39, 8'h00, 8'h9A, 8'h67, 8'h59, 8'h44, 8'h44, 8'h44,
        8'h6C, 8'h6C, 8'h6C, 8'h9A, 8'hD2, 8'h84, 8'h6C, 8'h5E, 8'hB5, 8'h95, 8'h95, 8'h95
    };

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        draw_valid;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [7:0]  glyph;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic        irq_pulse;
        logic        halt_request;
    } t_out_item;

    typedef enum logic [1:0] {
        DIV_COL = 2'd0,
        DIV_X   = 2'd1,
        DIV_Y   = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     clear;
        logic     latch;
        logic     exec;
        logic     capture;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_take;
        logic     pal;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic draw;
        logic div_done;
        logic pal_last;
    } t_sts;

    // Palette power-up contents: the base table twice
    function automatic logic [7:0] pal_init(input logic [PAL_AW-1:0] idx);
        logic [PAL_AW-1:0] k;
        k = (idx >= 7'd48) ? idx - 7'd48 : idx;
        return BASE_COLORS[k[5:0]];
    endfunction

endpackage

// File: rtl/tdc_div.sv
// ----------------------------------------------------------------------------
// tdc_div
// Restoring divider, one quotient bit per cycle, 17-bit by 8-bit.
// ----------------------------------------------------------------------------
module tdc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tdc_pkg::DIV_W-1:0] i_dividend,
    input  logic [7:0]                i_divisor,
    output logic                      o_done,
    output logic [tdc_pkg::DIV_W-1:0] o_quot,
    output logic [7:0]                o_rem
);
    import tdc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_q;
    logic [7:0]           r_r;
    logic [7:0]           r_d;
    logic [8:0]           trial;
    logic [8:0]           diff;
    logic                 ge;

    assign trial = {r_r, r_q[DIV_W-1]};
    assign diff  = trial - {1'b0, r_d};
    assign ge    = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == DIV_CNT_W'(DIV_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_W-2:0], ge};
            r_r <= ge ? diff[7:0] : trial[7:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// File: rtl/tdc_dp.sv
// ----------------------------------------------------------------------------
// tdc_dp
// Datapath: cell and palette memories, register page, address decode,
// position arithmetic and result assembly.
// ----------------------------------------------------------------------------
module tdc_dp #(
    parameter int CELL_DEPTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdc_pkg::t_cmd                 i_cmd,
    output tdc_pkg::t_sts                 o_sts,
    input  tdc_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [tdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    output tdc_pkg::t_out_item            o_result
);
    import tdc_pkg::*;

    localparam int          AW      = $clog2(CELL_DEPTH);
    localparam logic [16:0] DEPTH17 = 17'(CELL_DEPTH);

    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_REG  = 3'd1,
        SRC_ATTR = 3'd2,
        SRC_CHAR = 3'd3,
        SRC_PAL  = 3'd4
    } t_src;

    // Memories
    logic [7:0] char_mem [CELL_DEPTH];
    logic [7:0] attr_mem [CELL_DEPTH];
    logic [7:0] pal_mem  [PAL_DEPTH];
    logic [7:0] r_char_q;
    logic [7:0] r_attr_q;
    logic [7:0] r_pal_q;

    // Registers
    logic [7:0] r_sw, r_sh;
    logic [7:0] r_left, r_top, r_cols, r_rows;
    logic [7:0] r_char_page, r_attr_page, r_charset, r_irq_stat, r_irq_en;
    logic [AW-1:0] r_clr;
    t_in_item   r_item;
    t_src       r_src;
    logic [7:0] r_rd;
    logic       r_irq, r_halt, r_draw, r_is_attr;
    logic [15:0] r_off;
    logic [7:0] r_glyph, r_attr;
    logic [15:0] r_quo;
    logic [7:0] r_col, r_x, r_y;
    logic [2:0] r_pcnt;
    logic [47:0] r_rgb;
    t_out_item  r_res;

    // Decode
    logic [7:0]  page, lo, wd;
    logic [15:0] prod;
    logic [16:0] bsum;
    logic [8:0]  banks;
    logic        attr_hit, char_hit, io_hit, cell_hit, in_range, sizes_ok;
    logic        is_rd, is_wr, reg_wr, pal_sel, pal_ok, tick;
    logic [15:0] off;
    logic [AW-1:0] idx;
    logic        cell_wr, pal_wr;
    logic [7:0]  reg_val;
    logic [7:0]  stat_set;

    assign page = r_item.address[15:8];
    assign lo   = r_item.address[7:0];
    assign wd   = r_item.write_data;
    assign prod = r_cols * r_rows;
    assign bsum = {1'b0, prod} + 17'd255;
    assign banks = bsum[16:8];
    assign attr_hit = (page >= r_attr_page) &&
                      ({2'b0, page} < {2'b0, r_attr_page} + {1'b0, banks});
    assign char_hit = (page >= r_char_page) &&
                      ({2'b0, page} < {2'b0, r_char_page} + {1'b0, banks});
    assign io_hit   = !attr_hit && !char_hit && (page == IO_PAGE);
    assign cell_hit = attr_hit || char_hit;
    assign off      = attr_hit ? r_item.address - {r_attr_page, 8'h00}
                               : r_item.address - {r_char_page, 8'h00};
    assign in_range = ({1'b0, off} < DEPTH17);
    assign idx      = off[AW-1:0];
    assign sizes_ok = (r_sw != 8'd0) && (r_sh != 8'd0);
    assign is_rd    = (r_item.func == FN_READ);
    assign is_wr    = (r_item.func == FN_WRITE);
    assign pal_sel  = io_hit && lo[7];
    assign pal_ok   = pal_sel && ({1'b0, lo[6:0]} < 8'(PAL_DEPTH));
    assign reg_wr   = io_hit && !lo[7] && is_wr;
    assign cell_wr  = i_cmd.exec && cell_hit && in_range && is_wr && sizes_ok;
    assign pal_wr   = i_cmd.exec && pal_ok && is_wr;
    assign tick     = i_cmd.exec && ((r_item.func == FN_TICK) ||
                      (reg_wr && lo == REG_CONTROL && !wd[0] && wd[1]));
    assign stat_set = r_irq_stat | 8'h01;

    always_comb begin
        unique case (lo)
            REG_WIN_LEFT:   reg_val = r_left;
            REG_WIN_TOP:    reg_val = r_top;
            REG_WIN_COLS:   reg_val = r_cols;
            REG_WIN_ROWS:   reg_val = r_rows;
            REG_SCREEN_W:   reg_val = r_sw;
            REG_SCREEN_H:   reg_val = r_sh;
            REG_CHAR_PAGE:  reg_val = r_char_page;
            REG_ATTR_PAGE:  reg_val = r_attr_page;
            REG_CHARSET:    reg_val = r_charset;
            REG_IRQ_ENABLE: reg_val = r_irq_en;
            REG_IRQ_STATUS: reg_val = r_irq_stat;
            default:        reg_val = 8'h00;
        endcase
    end

    // Read source and register read value for the decoded access
    t_src       src_c;
    logic [7:0] rd_c;

    always_comb begin
        src_c = SRC_NONE;
        rd_c  = 8'h00;
        if (is_rd) begin
            if (cell_hit && in_range) begin
                src_c = attr_hit ? SRC_ATTR : SRC_CHAR;
            end else if (pal_ok) begin
                src_c = SRC_PAL;
            end else if (io_hit && !lo[7]) begin
                src_c = SRC_REG;
                rd_c  = reg_val;
            end
        end
    end

    // Memory ports: clear sweep, else the decoded access
    logic [AW-1:0]     mem_wa;
    logic [7:0]        chr_wd, atr_wd, pal_wd;
    logic              chr_we, atr_we, pal_we;
    logic [PAL_AW-1:0] pal_wa, pal_ra;
    logic [PAL_AW-1:0] fg_idx, bg_idx;

    assign fg_idx = PAL_AW'(({3'b0, r_attr[7:4]} + PAL_FG_BASE[6:0]) * 7'd3);
    assign bg_idx = PAL_AW'({3'b0, r_attr[3:0]} * 7'd3);

    always_comb begin
        mem_wa = i_cmd.clear ? r_clr : idx;
        chr_wd = i_cmd.clear ? CHAR_BLANK : wd;
        atr_wd = i_cmd.clear ? ATTR_INIT : wd;
        chr_we = i_cmd.clear || (cell_wr && !attr_hit);
        atr_we = i_cmd.clear || (cell_wr && attr_hit);
        pal_wa = i_cmd.clear ? r_clr[PAL_AW-1:0] : lo[6:0];
        pal_wd = i_cmd.clear ? pal_init(r_clr[PAL_AW-1:0]) : wd;
        pal_we = (i_cmd.clear && (r_clr < AW'(PAL_DEPTH))) || pal_wr;
        if (i_cmd.pal) begin
            pal_ra = (r_pcnt < 3'd3) ? fg_idx + PAL_AW'(r_pcnt)
                                     : bg_idx + PAL_AW'(r_pcnt - 3'd3);
        end else begin
            pal_ra = lo[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chr_we) begin
            char_mem[mem_wa] <= chr_wd;
        end
        if (atr_we) begin
            attr_mem[mem_wa] <= atr_wd;
        end
        r_char_q <= char_mem[idx];
        r_attr_q <= attr_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_wa] <= pal_wd;
        end
        if (pal_ra < PAL_AW'(PAL_DEPTH)) begin
            r_pal_q <= pal_mem[pal_ra];
        end else begin
            r_pal_q <= 8'h00;
        end
    end

    // Control and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_sw        <= 8'd80;
            r_sh        <= 8'd25;
            r_left      <= 8'd0;
            r_top       <= 8'd0;
            r_cols      <= 8'd40;
            r_rows      <= 8'd25;
            r_char_page <= 8'h04;
            r_attr_page <= 8'hd8;
            r_charset   <= 8'h00;
            r_irq_stat  <= 8'h00;
            r_irq_en    <= 8'h00;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SCREEN_W: r_sw <= i_cfg_data;
                    CFG_SCREEN_H: r_sh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec && reg_wr) begin
                unique case (lo)
                    REG_WIN_LEFT:   r_left      <= wd;
                    REG_WIN_TOP:    r_top       <= wd;
                    REG_WIN_COLS:   r_cols      <= wd;
                    REG_WIN_ROWS:   r_rows      <= wd;
                    REG_CHAR_PAGE:  r_char_page <= wd;
                    REG_ATTR_PAGE:  r_attr_page <= wd;
                    REG_CHARSET:    r_charset   <= wd;
                    REG_IRQ_ENABLE: r_irq_en    <= wd;
                    REG_IRQ_STATUS: r_irq_stat  <= r_irq_stat ^ wd;
                    default: ;
                endcase
            end
            if (tick) begin
                r_irq_stat <= stat_set;
            end
        end
    end

    // Per-transaction payload
    logic [7:0] glyph_c, attr_c;
    assign glyph_c = r_is_attr ? r_char_q : r_item.write_data;
    assign attr_c  = r_is_attr ? r_item.write_data : r_attr_q;

    logic             div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [7:0]       div_dvs;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [7:0]       div_rem;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_COL: begin
                div_dvd = {1'b0, r_off};
                div_dvs = r_cols;
            end
            DIV_X: begin
                div_dvd = DIV_W'({1'b0, r_col} + {1'b0, r_left});
                div_dvs = r_sw;
            end
            default: begin
                div_dvd = {1'b0, r_quo} + {9'b0, r_top};
                div_dvs = r_sh;
            end
        endcase
    end
    assign div_start = i_cmd.div_start;

    tdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_src     <= src_c;
            r_rd      <= rd_c;
            r_irq     <= tick && !r_irq_stat[0] && ((stat_set & r_irq_en) != 8'h00);
            r_halt    <= reg_wr && (lo == REG_CONTROL) && wd[0];
            r_draw    <= cell_wr && (r_cols != 8'd0);
            r_is_attr <= attr_hit;
            r_off     <= off;
        end
        if (i_cmd.capture) begin
            case (r_src)
                SRC_ATTR: r_rd <= r_attr_q;
                SRC_CHAR: r_rd <= r_char_q;
                SRC_PAL:  r_rd <= r_pal_q;
                default:  ;
            endcase
            r_glyph <= glyph_c;
            r_attr  <= glyph_c[7] ? {attr_c[3:0], attr_c[7:4]} : attr_c;
            r_pcnt  <= 3'd0;
        end
        if (i_cmd.div_take) begin
            unique case (i_cmd.div_sel)
                DIV_COL: begin
                    r_quo <= div_quot[15:0];
                    r_col <= div_rem;
                end
                DIV_X:   r_x <= div_rem;
                default: r_y <= div_rem;
            endcase
        end
        if (i_cmd.pal) begin
            r_pcnt <= r_pcnt + 1'b1;
            if (r_pcnt != 3'd0) begin
                r_rgb <= {r_rgb[39:0], r_pal_q};
            end
        end
        if (i_cmd.emit) begin
            r_res.read_data    <= r_rd;
            r_res.draw_valid   <= r_draw;
            r_res.cell_x       <= r_draw ? r_x : 8'h00;
            r_res.cell_y       <= r_draw ? r_y : 8'h00;
            r_res.glyph        <= r_draw ? r_glyph : 8'h00;
            r_res.fg_rgb       <= r_draw ? r_rgb[47:24] : 24'h0;
            r_res.bg_rgb       <= r_draw ? r_rgb[23:0] : 24'h0;
            r_res.irq_pulse    <= r_irq;
            r_res.halt_request <= r_halt;
        end
    end

    assign o_sts.clear_last = (r_clr == AW'(CELL_DEPTH - 1));
    assign o_sts.draw       = r_draw;
    assign o_sts.div_done   = div_done;
    assign o_sts.pal_last   = (r_pcnt == 3'd6);
    assign o_result         = r_res;

endmodule

// File: rtl/tdc_ctrl.sv
// ----------------------------------------------------------------------------
// tdc_ctrl
// Sequencer: memory clear sweep, decode, position divides, palette fetch.
// ----------------------------------------------------------------------------
module tdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tdc_pkg::t_sts i_sts,
    output tdc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import tdc_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_DEC   = 12'b0000_0000_0100,
        S_MEM   = 12'b0000_0000_1000,
        S_QS    = 12'b0000_0001_0000,
        S_QW    = 12'b0000_0010_0000,
        S_XS    = 12'b0000_0100_0000,
        S_XW    = 12'b0000_1000_0000,
        S_YS    = 12'b0001_0000_0000,
        S_YW    = 12'b0010_0000_0000,
        S_PAL   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_COL;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_MEM;
            end
            S_MEM: begin
                o_cmd.capture = 1'b1;
                n_state = i_sts.draw ? S_QS : S_DONE;
            end
            S_QS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_QW;
            end
            S_QW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = S_XS;
                end
            end
            S_XS: begin
                o_cmd.div_sel   = DIV_X;
                o_cmd.div_start = 1'b1;
                n_state = S_XW;
            end
            S_XW: begin
                o_cmd.div_sel = DIV_X;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = S_YS;
                end
            end
            S_YS: begin
                o_cmd.div_sel   = DIV_Y;
                o_cmd.div_start = 1'b1;
                n_state = S_YW;
            end
            S_YW: begin
                o_cmd.div_sel = DIV_Y;
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = S_PAL;
                end
            end
            S_PAL: begin
                o_cmd.pal = 1'b1;
                if (i_sts.pal_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// File: rtl/text_display_controller.sv
// ----------------------------------------------------------------------------
// text_display_controller
// Text-mode display device on an 8-bit CPU bus with draw command output.
// ----------------------------------------------------------------------------
// Each transaction (bus read, bus write or frame tick) is taken when i_start
// is high and o_busy is low, and gives exactly one result on o_result, marked
// by o_done for a single cycle; the receiver cannot stall, so capture the
// result in that cycle. A read, a register write, a palette access or a tick
// passes only through the decode, memory and done states. A character or
// color cell write that draws runs three passes through one shared bit-serial
// divider (each pass: a start state, 17 quotient steps and a wait for done,
// for the window column/row split and the two wraps to the screen size), then
// a palette fetch. After reset the block sweeps the cell memories to blanks
// and loads the palette, with o_busy high; screen size writes on the config
// port are taken at any time.
module text_display_controller #(
    parameter int CELL_DEPTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  tdc_pkg::t_in_item             i_item,
    output logic                          o_done,
    output tdc_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [tdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data
);
    import tdc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence each transaction
    tdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // Hold stores, registers and arithmetic
    tdc_dp #(
        .CELL_DEPTH (CELL_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

    // A result only follows a transaction in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without a transaction in flight");

    // Draw colors and position stay zero when no draw is issued
    a_nodraw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.draw_valid) |->
        (o_result.fg_rgb == 24'h0 && o_result.bg_rgb == 24'h0 &&
         o_result.cell_x == 8'h00 && o_result.cell_y == 8'h00))
        else $error("draw fields set without draw_valid");

    // One result per transaction, and o_done strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

endmodule
